[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Clock and reset names are taken from the including module (clk, rst_n).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define DAP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dap assertion failed");

// Checked on every rising edge, reset included.
`define DAP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dap assertion failed");

`endif

[rtl/dap_pkg.sv]
// Package for the data-processing ALU/shifter: opcodes, condition table,
// classified item and status types. No dependencies.
`timescale 1ns / 1ps

package dap_pkg;

  typedef enum logic [3:0] {
    OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
    OP_TST, OP_TEQ, OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC, OP_MVN
  } dap_op_t;

  typedef enum logic [1:0] {
    SH_LSL, SH_LSR, SH_ASR, SH_ROR
  } dap_shift_t;

  localparam logic [15:0] LOGIC_OPS   = 16'hf303;
  localparam logic [15:0] WRITING_OPS = 16'hf0ff;

  // Pass mask per condition code, indexed by the NZCV value.
  localparam logic [15:0] COND_PASS [16] = '{
    16'hf0f0, 16'h0f0f, 16'hcccc, 16'h3333, 16'hff00, 16'h00ff, 16'haaaa, 16'h5555,
    16'h0c0c, 16'hf3f3, 16'haa55, 16'h55aa, 16'h0a05, 16'hf5fa, 16'hffff, 16'h0000
  };

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Item after decode and operand-two shifting, awaiting execution.
  typedef struct packed {
    logic [3:0]  cond;
    dap_op_t     opcode;
    logic        set_flags;
    logic        writes;
    logic        logic_op;
    logic        to_pc;
    logic [31:0] op1;
    logic [31:0] op2;
    logic        op2_rrx;   // bit 31 of op2 is the old C
    logic        sc_old;    // shifter carry is the old C
    logic        sc_val;
  } dap_cls_t;

  typedef struct packed {
    logic        executed;
    logic [31:0] result;
    logic        write_dest;
    logic [3:0]  flags_out;
    logic        pc_step;
  } dap_res_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } dap_q_stat_t;

  typedef struct packed {
    logic [3:0] flags;
    logic       out_busy;
  } dap_bk_stat_t;

endpackage

[rtl/dap_in_if.sv]
// Input channel of the data-processing ALU/shifter: handshake and fields.
// No dependencies.
`timescale 1ns / 1ps

interface dap_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cond;
  logic [3:0]  opcode;
  logic        set_flags;
  logic        imm_form;
  logic        reg_shift;
  logic [1:0]  shift_type;
  logic [7:0]  shift_amount;
  logic [3:0]  rotate_field;
  logic [31:0] first_operand;
  logic [31:0] second_source;
  logic        dest_is_pc;

  modport source (
    output valid, cond, opcode, set_flags, imm_form, reg_shift, shift_type,
           shift_amount, rotate_field, first_operand, second_source, dest_is_pc,
    input  ready
  );
  modport sink (
    input  valid, cond, opcode, set_flags, imm_form, reg_shift, shift_type,
           shift_amount, rotate_field, first_operand, second_source, dest_is_pc,
    output ready
  );
endinterface

[rtl/dap_out_if.sv]
// Result channel of the data-processing ALU/shifter: handshake and fields.
// No dependencies.
`timescale 1ns / 1ps

interface dap_out_if;
  logic        valid;
  logic        ready;
  logic        executed;
  logic [31:0] result;
  logic        write_dest;
  logic [3:0]  flags_out;
  logic        pc_step;

  modport source (
    output valid, executed, result, write_dest, flags_out, pc_step,
    input  ready
  );
  modport sink (
    input  valid, executed, result, write_dest, flags_out, pc_step,
    output ready
  );
endinterface

[rtl/dap_front.sv]
// Front end: accepts items, decodes the opcode class and forms operand two
// through the barrel shifter. Depends on dap_pkg and dap_in_if.
`timescale 1ns / 1ps

module dap_front (
  dap_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output dap_pkg::dap_cls_t push_item
);
  import dap_pkg::*;

  dap_shift_t  sh;
  logic [31:0] rm;
  logic [4:0]  a5;
  logic [4:0]  s5;
  logic [4:0]  rot;
  logic [7:0]  amt_eff;
  logic        big;
  logic        exact32;
  logic [31:0] imm32;
  logic [63:0] rotw;
  logic [63:0] rorw;
  logic [32:0] lslw;
  logic [32:0] lsrw;
  logic [32:0] asrw;
  logic [31:0] op2;
  logic        rrx;
  logic        sc_old;
  logic        sc_val;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    sh      = dap_shift_t'(in_ch.shift_type);
    rm      = in_ch.second_source;
    a5      = in_ch.shift_amount[4:0];
    rot     = {in_ch.rotate_field, 1'b0};
    imm32   = {24'b0, rm[7:0]};
    rotw    = {imm32, imm32} >> rot;
    amt_eff = in_ch.reg_shift ? in_ch.shift_amount
                              : ((a5 == 5'd0) ? 8'd32 : {3'b0, a5});
    big     = (amt_eff[7:5] != 3'd0);
    exact32 = (amt_eff == 8'd32);
    s5      = amt_eff[4:0];
    lslw    = {1'b0, rm} << s5;
    lsrw    = {rm, 1'b0} >> s5;
    asrw    = 33'($signed({rm, 1'b0}) >>> s5);
    rorw    = {rm, rm} >> s5;
    op2     = rm;
    rrx     = 1'b0;
    sc_old  = 1'b0;
    sc_val  = 1'b0;
    priority if (in_ch.imm_form) begin
      op2    = rotw[31:0];
      sc_old = (in_ch.rotate_field == 4'd0);
      sc_val = rotw[31];
    end else if (in_ch.reg_shift ? (in_ch.shift_amount == 8'd0)
                                 : (sh == SH_LSL && a5 == 5'd0)) begin
      sc_old = 1'b1;
    end else if (!in_ch.reg_shift && sh == SH_ROR && a5 == 5'd0) begin
      op2    = {1'b0, rm[31:1]};
      rrx    = 1'b1;
      sc_val = rm[0];
    end else begin
      unique case (sh)
        SH_LSL: begin
          op2    = big ? 32'd0 : lslw[31:0];
          sc_val = big ? (exact32 & rm[0]) : lslw[32];
        end
        SH_LSR: begin
          op2    = big ? 32'd0 : lsrw[32:1];
          sc_val = big ? (exact32 & rm[31]) : lsrw[0];
        end
        SH_ASR: begin
          op2    = big ? {32{rm[31]}} : asrw[32:1];
          sc_val = big ? rm[31] : asrw[0];
        end
        SH_ROR: begin
          op2    = (s5 == 5'd0) ? rm : rorw[31:0];
          sc_val = (s5 == 5'd0) ? rm[31] : rorw[31];
        end
        default: begin
          op2 = rm;
        end
      endcase
    end
  end

  always_comb begin
    push_item.cond      = in_ch.cond;
    push_item.opcode    = dap_op_t'(in_ch.opcode);
    push_item.set_flags = in_ch.set_flags;
    push_item.writes    = WRITING_OPS[in_ch.opcode];
    push_item.logic_op  = LOGIC_OPS[in_ch.opcode];
    push_item.to_pc     = in_ch.dest_is_pc;
    push_item.op1       = in_ch.first_operand;
    push_item.op2       = op2;
    push_item.op2_rrx   = rrx;
    push_item.sc_old    = sc_old;
    push_item.sc_val    = sc_val;
  end

endmodule

[rtl/dap_queue.sv]
// Short FIFO of decoded items between front and back end.
// Depends on dap_pkg.
`timescale 1ns / 1ps

module dap_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dap_pkg::dap_cls_t   push_item,
  input  logic                pop,
  output dap_pkg::dap_cls_t   head_item,
  output dap_pkg::dap_q_stat_t stat
);
  import dap_pkg::*;

  dap_cls_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = entry_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);

endmodule

[rtl/dap_back.sv]
// Back end: condition check, ALU, flag register and output register.
// Depends on dap_pkg and dap_out_if.
`timescale 1ns / 1ps

module dap_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dap_pkg::dap_cls_t     head_item,
  input  logic                  q_empty,
  output logic                  pop,
  dap_out_if.source             out_ch,
  output dap_pkg::dap_bk_stat_t stat
);
  import dap_pkg::*;

  logic [3:0]  flags_r, flags_nxt;
  logic        out_valid_r, out_valid_nxt;
  dap_res_t    out_r;
  dap_res_t    res;
  logic        take;
  logic        pass;
  logic        c_old;
  logic [31:0] op2;
  logic        sc;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_cin;
  logic [32:0] sum;
  logic        av;
  logic [31:0] alu;
  logic [3:0]  new_flags;

  assign take = !out_valid_r || out_ch.ready;
  assign pop  = take && !q_empty;

  always_comb begin
    c_old = flags_r[1];
    pass  = COND_PASS[head_item.cond][flags_r];
    op2   = head_item.op2_rrx ? {c_old, head_item.op2[30:0]} : head_item.op2;
    sc    = head_item.sc_old ? c_old : head_item.sc_val;

    unique case (head_item.opcode)
      OP_RSB:         begin add_a = op2;           add_b = ~head_item.op1; add_cin = 1'b1;  end
      OP_ADD, OP_CMN: begin add_a = head_item.op1; add_b = op2;            add_cin = 1'b0;  end
      OP_ADC:         begin add_a = head_item.op1; add_b = op2;            add_cin = c_old; end
      OP_SBC:         begin add_a = head_item.op1; add_b = ~op2;           add_cin = c_old; end
      OP_RSC:         begin add_a = op2;           add_b = ~head_item.op1; add_cin = c_old; end
      default:        begin add_a = head_item.op1; add_b = ~op2;           add_cin = 1'b1;  end
    endcase
    sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
    av  = ~(add_a[31] ^ add_b[31]) & (add_a[31] ^ sum[31]);

    unique case (head_item.opcode)
      OP_AND, OP_TST: alu = head_item.op1 & op2;
      OP_EOR, OP_TEQ: alu = head_item.op1 ^ op2;
      OP_ORR:         alu = head_item.op1 | op2;
      OP_MOV:         alu = op2;
      OP_BIC:         alu = head_item.op1 & ~op2;
      OP_MVN:         alu = ~op2;
      default:        alu = sum[31:0];
    endcase

    new_flags[3] = alu[31];
    new_flags[2] = (alu == 32'd0);
    new_flags[1] = head_item.logic_op ? sc : sum[32];
    new_flags[0] = head_item.logic_op ? flags_r[0] : av;

    flags_nxt = flags_r;
    if (pass && head_item.set_flags) begin
      flags_nxt = new_flags;
    end

    res.executed   = pass;
    res.result     = (pass && (head_item.writes || head_item.set_flags)) ? alu : 32'd0;
    res.write_dest = pass && head_item.writes;
    res.flags_out  = flags_nxt;
    res.pc_step    = pass && head_item.writes && head_item.to_pc;

    out_valid_nxt = take ? !q_empty : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.executed   = out_r.executed;
  assign out_ch.result     = out_r.result;
  assign out_ch.write_dest = out_r.write_dest;
  assign out_ch.flags_out  = out_r.flags_out;
  assign out_ch.pc_step    = out_r.pc_step;

  assign stat.flags    = flags_r;
  assign stat.out_busy = out_valid_r;

endmodule

[rtl/dataproc_alu_shifter_core.sv]
// Top level of the data-processing ALU/shifter: front end, item queue, back end.
// Depends on dap_pkg, dap_in_if, dap_out_if, dap_front, dap_queue, dap_back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Executes one 32-bit data-processing instruction per item: condition test
// against the held NZCV flags, rotated immediate or barrel-shifted register
// operand, one of 16 ALU operations and an optional flag update. One item is
// taken per cycle and one result leaves per cycle while neither side stalls;
// the rate is set by the back end, where condition check, adder and flag
// write form a loop. From acceptance to a valid result, the front end shifts
// operand two into a two-entry queue, and the back end executes from the
// queue head into the output register. Either side may stall; the queue
// absorbs up to two items. Flags reset to zero.
module dataproc_alu_shifter_core (
  input  logic       clk,
  input  logic       rst_n,
  dap_in_if.sink     in_ch,
  dap_out_if.source  out_ch
);
  import dap_pkg::*;

  logic         push;
  logic         pop;
  dap_cls_t     push_item;
  dap_cls_t     head_item;
  dap_q_stat_t  q_stat;
  dap_bk_stat_t bk_stat;

  dap_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_stat.full),
    .push      (push),
    .push_item (push_item)
  );

  dap_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  dap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_ch    (out_ch),
    .stat      (bk_stat)
  );

  `DAP_ASSERT(a_flags_track_out, out_ch.valid |-> out_ch.flags_out == bk_stat.flags)
  `DAP_ASSERT(a_skip_no_effect, out_ch.valid && !out_ch.executed |-> !out_ch.write_dest && !out_ch.pc_step && out_ch.result == 32'd0)
  `DAP_ASSERT(a_pc_step_writes, out_ch.valid && out_ch.pc_step |-> out_ch.write_dest && out_ch.executed)
  `DAP_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !bk_stat.out_busy && q_stat.empty && bk_stat.flags == 4'd0)

endmodule

[tb/sv/tb_dataproc_alu_shifter_core.sv]
// Testbench for dataproc_alu_shifter_core: directed and random instructions,
// checked against a predictor of the condition test, shifter, ALU and flags.
// Depends on dap_pkg, dap_in_if, dap_out_if and the core itself.
`timescale 1ns / 1ps

module tb_dataproc_alu_shifter_core;
  import dap_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int ITEMS_PER_PHASE = 400;

  typedef enum logic [3:0] {
    CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
    CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_AL, CC_NV
  } cc_t;

  typedef struct {
    cc_t         cond;
    dap_op_t     opcode;
    logic        set_flags;
    logic        imm_form;
    logic        reg_shift;
    dap_shift_t  shift_type;
    logic [7:0]  shift_amount;
    logic [3:0]  rotate_field;
    logic [31:0] first_operand;
    logic [31:0] second_source;
    logic        dest_is_pc;
  } dp_instr_t;

  class dataproc_scoreboard;
    logic [3:0] nzcv;
    dap_res_t   expected_q[$];
    int         errors;

    function new();
      nzcv = 4'h0;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int unsigned n);
      int unsigned k;
      k = n & 31;
      if (k == 0) return x;
      return (x >> k) | (x << (32 - k));
    endfunction

    function logic [31:0] barrel(logic [31:0] rm, dap_shift_t ty, logic [7:0] amt_in,
                                 logic by_reg, logic cin, output logic cout);
      int unsigned amt;
      amt = 32'(amt_in);
      if (!by_reg) begin
        amt = amt & 31;
        if (ty == SH_LSL && amt == 0) begin
          cout = cin;
          return rm;
        end
        if (ty == SH_ROR && amt == 0) begin
          cout = rm[0];
          return {cin, rm[31:1]};
        end
        if (amt == 0) amt = 32;
      end else if (amt == 0) begin
        cout = cin;
        return rm;
      end
      case (ty)
        SH_LSL: begin
          if (amt < 32) begin
            cout = rm[32 - amt];
            return rm << amt;
          end
          cout = (amt == 32) ? rm[0] : 1'b0;
          return 32'h0;
        end
        SH_LSR: begin
          if (amt < 32) begin
            cout = rm[amt - 1];
            return rm >> amt;
          end
          cout = (amt == 32) ? rm[31] : 1'b0;
          return 32'h0;
        end
        SH_ASR: begin
          if (amt < 32) begin
            cout = rm[amt - 1];
            return $signed(rm) >>> amt;
          end
          cout = rm[31];
          return {32{rm[31]}};
        end
        default: begin
          amt = amt & 31;
          if (amt == 0) begin
            cout = rm[31];
            return rm;
          end
          cout = rm[amt - 1];
          return ror32(rm, amt);
        end
      endcase
    endfunction

    function logic [31:0] add_with_carry(logic [31:0] a, logic [31:0] b, logic cin,
                                         output logic cout, output logic ovf);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b} + {32'h0, cin};
      cout = sum[32];
      ovf = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
      return sum[31:0];
    endfunction

    function void note_instr(dp_instr_t it);
      dap_res_t    r;
      logic [31:0] op1, op2, res;
      logic        sc, ac, av, n, z, c, v, writes, is_logic;
      op1 = it.first_operand;
      {n, z, c, v} = nzcv;
      ac = 1'b0;
      av = 1'b0;
      writes = WRITING_OPS[it.opcode];
      is_logic = LOGIC_OPS[it.opcode];
      if (!COND_PASS[it.cond][nzcv]) begin
        r = '{executed: 1'b0, result: 32'h0, write_dest: 1'b0, flags_out: nzcv,
              pc_step: 1'b0};
        expected_q.push_back(r);
        return;
      end
      if (it.imm_form) begin
        op2 = ror32({24'h0, it.second_source[7:0]}, 2 * it.rotate_field);
        sc = (it.rotate_field != 0) ? op2[31] : c;
      end else begin
        op2 = barrel(it.second_source, it.shift_type, it.shift_amount, it.reg_shift, c, sc);
      end
      case (it.opcode)
        OP_AND, OP_TST: res = op1 & op2;
        OP_EOR, OP_TEQ: res = op1 ^ op2;
        OP_SUB, OP_CMP: res = add_with_carry(op1, ~op2, 1'b1, ac, av);
        OP_RSB:         res = add_with_carry(op2, ~op1, 1'b1, ac, av);
        OP_ADD, OP_CMN: res = add_with_carry(op1, op2, 1'b0, ac, av);
        OP_ADC:         res = add_with_carry(op1, op2, c, ac, av);
        OP_SBC:         res = add_with_carry(op1, ~op2, c, ac, av);
        OP_RSC:         res = add_with_carry(op2, ~op1, c, ac, av);
        OP_ORR:         res = op1 | op2;
        OP_MOV:         res = op2;
        OP_BIC:         res = op1 & ~op2;
        default:        res = ~op2;
      endcase
      if (!writes && !it.set_flags) begin
        res = 32'h0;
      end else if (it.set_flags) begin
        n = res[31];
        z = (res == 32'h0);
        if (is_logic) begin
          c = sc;
        end else begin
          c = ac;
          v = av;
        end
        nzcv = {n, z, c, v};
      end
      r = '{executed: 1'b1, result: res, write_dest: writes, flags_out: nzcv,
            pc_step: writes & it.dest_is_pc};
      expected_q.push_back(r);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] seen);
      errors++;
      if (errors <= 100)
        $display("%0t: %s expected %h, got %h", $time, what, want, seen);
    endfunction

    function void check_result(dap_res_t got);
      dap_res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: result item with none pending, expected nothing, got %h",
                   $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.executed !== want.executed)
        report("executed", 32'(want.executed), 32'(got.executed));
      if (got.result !== want.result)
        report("result", want.result, got.result);
      if (got.write_dest !== want.write_dest)
        report("write_dest", 32'(want.write_dest), 32'(got.write_dest));
      if (got.flags_out !== want.flags_out)
        report("flags_out", 32'(want.flags_out), 32'(got.flags_out));
      if (got.pc_step !== want.pc_step)
        report("pc_step", 32'(want.pc_step), 32'(got.pc_step));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;
  int   send_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   cycles = 0;
  dataproc_scoreboard sb;

  dap_in_if  in_ch ();
  dap_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  dataproc_alu_shifter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("dataproc_alu_shifter_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    dap_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.executed   = out_ch.executed;
      got.result     = out_ch.result;
      got.write_dest = out_ch.write_dest;
      got.flags_out  = out_ch.flags_out;
      got.pc_step    = out_ch.pc_step;
      sb.check_result(got);
    end
    sink_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic drive_instr(input dp_instr_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cond          <= it.cond;
    in_ch.opcode        <= it.opcode;
    in_ch.set_flags     <= it.set_flags;
    in_ch.imm_form      <= it.imm_form;
    in_ch.reg_shift     <= it.reg_shift;
    in_ch.shift_type    <= it.shift_type;
    in_ch.shift_amount  <= it.shift_amount;
    in_ch.rotate_field  <= it.rotate_field;
    in_ch.first_operand <= it.first_operand;
    in_ch.second_source <= it.second_source;
    in_ch.dest_is_pc    <= it.dest_is_pc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_instr(it);
  endtask

  function automatic dp_instr_t mk(cc_t cc, dap_op_t op, int s, int imm, int rsh,
                                   dap_shift_t st, logic [7:0] amt, logic [3:0] rot,
                                   logic [31:0] a, logic [31:0] b, int pc);
    dp_instr_t it;
    it = '{cond: cc, opcode: op, set_flags: 1'(s), imm_form: 1'(imm), reg_shift: 1'(rsh),
           shift_type: st, shift_amount: amt, rotate_field: rot, first_operand: a,
           second_source: b, dest_is_pc: 1'(pc)};
    return it;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic dp_instr_t rand_instr();
    dp_instr_t it;
    it.cond          = ($urandom_range(3) == 0) ? CC_AL : cc_t'($urandom_range(15));
    it.opcode        = dap_op_t'($urandom_range(15));
    it.set_flags     = ($urandom_range(9) < 7);
    it.imm_form      = ($urandom_range(9) < 3);
    it.reg_shift     = 1'($urandom_range(1));
    it.shift_type    = dap_shift_t'($urandom_range(3));
    case ($urandom_range(3))
      0:       it.shift_amount = 8'($urandom_range(31));
      1:       it.shift_amount = 8'($urandom_range(40));
      2:       it.shift_amount = 8'($urandom_range(7) * 32);
      default: it.shift_amount = 8'($urandom_range(255));
    endcase
    it.rotate_field  = 4'($urandom_range(15));
    it.first_operand = pick_word();
    it.second_source = pick_word();
    it.dest_is_pc    = ($urandom_range(4) == 0);
    return it;
  endfunction

  task automatic run_directed();
    // immediate carry: zero rotation keeps old C, nonzero takes bit 31
    drive_instr(mk(CC_AL, OP_MOV, 1, 1, 0, SH_LSL, 8'd0, 4'd0, 32'h0, 32'h0, 0));
    drive_instr(mk(CC_EQ, OP_MVN, 1, 1, 0, SH_LSL, 8'd0, 4'd1, 32'h0, 32'hffff_ffff, 0));
    drive_instr(mk(CC_EQ, OP_ADD, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'h1, 32'h1, 0));
    drive_instr(mk(CC_GT, OP_ORR, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'h0, 32'h0, 0));
    drive_instr(mk(CC_LE, OP_SUB, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'h0, 32'h1, 0));
    drive_instr(mk(CC_LT, OP_ADD, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'h7fff_ffff, 32'h1, 0));
    drive_instr(mk(CC_VS, OP_ADC, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'hffff_ffff, 32'h0, 0));
    drive_instr(mk(CC_NV, OP_MOV, 1, 1, 0, SH_LSL, 8'd0, 4'd0, 32'h0, 32'h0, 1));
    drive_instr(mk(CC_MI, OP_SBC, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'h0, 32'h0, 0));
    drive_instr(mk(CC_AL, OP_RSC, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'h1, 32'h0, 0));
    drive_instr(mk(CC_AL, OP_RSB, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'h0, 32'h0, 0));
    // immediate shift of zero: lsr and asr mean 32, ror means rrx
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 0, SH_LSR, 8'd0, 4'd0, 32'h0, 32'hffff_ffff, 0));
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 0, SH_ASR, 8'd0, 4'd0, 32'h0, 32'h8000_0000, 0));
    drive_instr(mk(CC_CS, OP_MOV, 1, 0, 0, SH_ROR, 8'd0, 4'd0, 32'h0, 32'h1, 0));
    // register shifts: zero, 32 and beyond
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 1, SH_LSL, 8'd0, 4'd0, 32'h0, 32'h1234_5678, 0));
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 1, SH_LSL, 8'd32, 4'd0, 32'h0, 32'h1, 0));
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 1, SH_LSL, 8'd33, 4'd0, 32'h0, 32'hffff_ffff, 0));
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 1, SH_LSR, 8'd32, 4'd0, 32'h0, 32'h8000_0000, 0));
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 1, SH_LSR, 8'd255, 4'd0, 32'h0, 32'hffff_ffff, 0));
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 1, SH_ASR, 8'd255, 4'd0, 32'h0, 32'h8000_0000, 0));
    drive_instr(mk(CC_AL, OP_MOV, 1, 0, 1, SH_ROR, 8'd64, 4'd0, 32'h0, 32'h8000_0001, 0));
    // compares with and without S (without S they leave flags alone and give no result), then logic ops
    drive_instr(mk(CC_AL, OP_TST, 0, 0, 0, SH_LSL, 8'd0, 4'd0, 32'hffff_ffff, 32'h1, 1));
    drive_instr(mk(CC_AL, OP_TEQ, 1, 1, 0, SH_LSL, 8'd0, 4'd15, 32'hffff_ffff,
                   32'hffff_ffff, 0));
    drive_instr(mk(CC_AL, OP_CMP, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'h8000_0000, 32'h1, 1));
    drive_instr(mk(CC_AL, OP_CMN, 1, 0, 0, SH_LSL, 8'd0, 4'd0, 32'hffff_ffff, 32'h1, 0));
    drive_instr(mk(CC_HI, OP_EOR, 1, 0, 1, SH_ROR, 8'd255, 4'd15, 32'hffff_ffff,
                   32'hffff_ffff, 1));
    drive_instr(mk(CC_AL, OP_BIC, 1, 0, 0, SH_LSL, 8'd31, 4'd0, 32'hffff_ffff, 32'h1, 1));
    drive_instr(mk(CC_AL, OP_AND, 0, 1, 0, SH_LSL, 8'd0, 4'd8, 32'hffff_ffff, 32'h0000_00a5,
                   1));
  endtask

  initial begin
    sb = new();
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.cond          <= CC_AL;
    in_ch.opcode        <= OP_AND;
    in_ch.set_flags     <= 1'b0;
    in_ch.imm_form      <= 1'b0;
    in_ch.reg_shift     <= 1'b0;
    in_ch.shift_type    <= SH_LSL;
    in_ch.shift_amount  <= 8'h0;
    in_ch.rotate_field  <= 4'h0;
    in_ch.first_operand <= 32'h0;
    in_ch.second_source <= 32'h0;
    in_ch.dest_is_pc    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 77;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          sink_stall_pct = 77;
        end
        default: begin
          send_idle_pct = 33;
          sink_stall_pct = 33;
        end
      endcase
      repeat (ITEMS_PER_PHASE) drive_instr(rand_instr());
    end
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("dataproc_alu_shifter_core: match");
    end else begin
      $display("dataproc_alu_shifter_core: mismatch");
    end
    $finish;
  end

endmodule
